>>> sv/bpi_pkg.sv
// ----------------------------------------------------------------------------
// bpi_pkg: shared types and constants
// Widths, formats and request types of the bicubic patch interpolator.
// ----------------------------------------------------------------------------
package bpi_pkg;

    localparam int SAMPLE_BITS = 8;
    localparam int FRAC_BITS   = 8;
    localparam int RES_W       = 18;
    // Working width of the cubic; covers the column pass on 18-bit row values.
    localparam int ACC_W       = 24;
    localparam int PROD_W      = ACC_W + FRAC_BITS + 1;

    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic [FRAC_BITS-1:0]    t_frac;
    typedef logic signed [RES_W-1:0] t_res;

    // One request to the shared multiply, round and add unit.
    typedef struct packed {
        t_acc  base;
        t_acc  mult;
        t_frac frac;
        logic  half;   // Extra right shift of one bit for the final t*c/2 term.
    } t_mac_req;

endpackage

>>> sv/bpi_mac.sv
// ----------------------------------------------------------------------------
// bpi_mac: multiply, round and add
// Returns base + round(frac * mult) at FRAC_BITS or FRAC_BITS+1 fraction bits,
// rounding to nearest with ties toward plus infinity.
// ----------------------------------------------------------------------------
module bpi_mac (
    input  bpi_pkg::t_mac_req i_req,
    output bpi_pkg::t_acc     o_sum
);

    logic signed [bpi_pkg::PROD_W-1:0] w_prod;
    logic signed [bpi_pkg::PROD_W-1:0] w_rnd;
    logic signed [bpi_pkg::PROD_W-1:0] w_shift;

    always_comb begin
        w_prod = i_req.mult * $signed({1'b0, i_req.frac});
        if (i_req.half) begin
            w_rnd   = w_prod + (bpi_pkg::PROD_W'(1) <<< bpi_pkg::FRAC_BITS);
            w_shift = w_rnd >>> (bpi_pkg::FRAC_BITS + 1);
        end else begin
            w_rnd   = w_prod + (bpi_pkg::PROD_W'(1) <<< (bpi_pkg::FRAC_BITS - 1));
            w_shift = w_rnd >>> bpi_pkg::FRAC_BITS;
        end
        o_sum = i_req.base + w_shift[bpi_pkg::ACC_W-1:0];
    end

endmodule

>>> sv/bpi_cubic.sv
// ----------------------------------------------------------------------------
// bpi_cubic: Catmull-Rom cubic sequencer
// Evaluates one cubic by Horner's rule in four steps, three of them on the shared unit.
// ----------------------------------------------------------------------------
module bpi_cubic (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  bpi_pkg::t_acc  i_p0,
    input  bpi_pkg::t_acc  i_p1,
    input  bpi_pkg::t_acc  i_p2,
    input  bpi_pkg::t_acc  i_p3,
    input  bpi_pkg::t_frac i_frac,
    output logic           o_done,
    output bpi_pkg::t_acc  o_result
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_A    = 3'd1;
    localparam logic [2:0] ST_B    = 3'd2;
    localparam logic [2:0] ST_C    = 3'd3;
    localparam logic [2:0] ST_D    = 3'd4;

    logic [2:0]     r_step, n_step;
    logic           r_done, n_done;
    bpi_pkg::t_acc  r_p0, r_p1, r_p2, r_p3;
    bpi_pkg::t_frac r_frac;
    bpi_pkg::t_acc  r_acc, n_acc;

    bpi_pkg::t_acc    w_a, w_bbase, w_cbase, w_diff, w_sum;
    bpi_pkg::t_mac_req w_req;

    bpi_mac u_mac (
        .i_req (w_req),
        .o_sum (w_sum)
    );

    always_comb begin
        w_diff  = r_p1 - r_p2;
        w_a     = (w_diff <<< 1) + w_diff + r_p3 - r_p0;
        w_bbase = (r_p0 <<< 1) - ((r_p1 <<< 2) + r_p1) + (r_p2 <<< 2) - r_p3;
        w_cbase = r_p2 - r_p0;

        w_req.mult = r_acc;
        w_req.frac = r_frac;
        w_req.half = (r_step == ST_D);
        unique case (r_step)
            ST_B:    w_req.base = w_bbase;
            ST_C:    w_req.base = w_cbase;
            default: w_req.base = r_p1;
        endcase

        n_step = r_step;
        n_acc  = r_acc;
        n_done = 1'b0;
        unique case (r_step)
            ST_IDLE: begin
                if (i_start) begin
                    n_step = ST_A;
                end
            end
            ST_A: begin
                n_acc  = w_a;
                n_step = ST_B;
            end
            ST_B: begin
                n_acc  = w_sum;
                n_step = ST_C;
            end
            ST_C: begin
                n_acc  = w_sum;
                n_step = ST_D;
            end
            ST_D: begin
                n_acc  = w_sum;
                n_done = 1'b1;
                n_step = ST_IDLE;
            end
            default: begin
                n_step = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
            r_done <= 1'b0;
        end else begin
            r_step <= n_step;
            r_done <= n_done;
        end
        r_acc <= n_acc;
        if (r_step == ST_IDLE && i_start) begin
            r_p0   <= i_p0;
            r_p1   <= i_p1;
            r_p2   <= i_p2;
            r_p3   <= i_p3;
            r_frac <= i_frac;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

>>> sv/bicubic_patch_interpolator_top.sv
// ----------------------------------------------------------------------------
// bicubic_patch_interpolator_top: Catmull-Rom bicubic patch interpolator
// Takes a 4x4 patch one row per request and returns one bicubic value.
// ----------------------------------------------------------------------------
// A patch arrives as four requests, one row of four samples each, with the
// row fraction frac_y; frac_x is taken from the fourth request. Each row is
// interpolated and kept; the fourth row also runs the cubic across the four
// row values and yields one signed, unclamped result with 8 fraction bits.
// Both cubics run on one shared multiply, round and add unit, four steps each.
// Rows one to three free the input once their cubic is done; the fourth row
// also waits for the column cubic and, while a result is held by i_stall, for the output.
// The output register lets the next patch start while a result is pending.
module bicubic_patch_interpolator_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [7:0]                     i_sample_0,
    input  logic [7:0]                     i_sample_1,
    input  logic [7:0]                     i_sample_2,
    input  logic [7:0]                     i_sample_3,
    input  logic [7:0]                     i_frac_y,
    input  logic [7:0]                     i_frac_x,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [17:0]             o_interpolated
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ROW  = 2'd1;
    localparam logic [1:0] S_COL  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    localparam int PAD_W = bpi_pkg::ACC_W - bpi_pkg::SAMPLE_BITS - bpi_pkg::FRAC_BITS;
    localparam int EXT_W = bpi_pkg::ACC_W - bpi_pkg::RES_W;

    logic [1:0]      r_state, n_state;
    logic [1:0]      r_row_cnt, n_row_cnt;
    bpi_pkg::t_res   r_rows [3];
    bpi_pkg::t_frac  r_frac_x;
    logic            r_out_valid, n_out_valid;
    bpi_pkg::t_res   r_out_data;

    logic            w_start;
    bpi_pkg::t_acc   w_p0, w_p1, w_p2, w_p3;
    bpi_pkg::t_frac  w_frac;
    logic            w_done;
    bpi_pkg::t_acc   w_result;
    bpi_pkg::t_res   w_wrapped;
    logic            w_out_free;

    bpi_cubic u_cubic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_p0     (w_p0),
        .i_p1     (w_p1),
        .i_p2     (w_p2),
        .i_p3     (w_p3),
        .i_frac   (w_frac),
        .o_done   (w_done),
        .o_result (w_result)
    );

    function automatic bpi_pkg::t_acc scale(input logic [7:0] s);
        scale = $signed({{PAD_W{1'b0}}, s[bpi_pkg::SAMPLE_BITS-1:0],
                         {bpi_pkg::FRAC_BITS{1'b0}}});
    endfunction

    function automatic bpi_pkg::t_acc extend(input bpi_pkg::t_res v);
        extend = $signed({{EXT_W{v[bpi_pkg::RES_W-1]}}, v});
    endfunction

    assign w_wrapped  = w_result[bpi_pkg::RES_W-1:0];
    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state     = r_state;
        n_row_cnt   = r_row_cnt;
        n_out_valid = r_out_valid && i_stall;
        w_start     = 1'b0;
        // The row pass reads the input ports; the column pass reads the stored rows.
        if (r_state == S_IDLE) begin
            w_p0   = scale(i_sample_0);
            w_p1   = scale(i_sample_1);
            w_p2   = scale(i_sample_2);
            w_p3   = scale(i_sample_3);
            w_frac = i_frac_y;
        end else begin
            w_p0   = extend(r_rows[0]);
            w_p1   = extend(r_rows[1]);
            w_p2   = extend(r_rows[2]);
            w_p3   = extend(w_wrapped);
            w_frac = r_frac_x;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    w_start = 1'b1;
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                if (w_done) begin
                    if (r_row_cnt == 2'd3) begin
                        w_start   = 1'b1;
                        n_row_cnt = 2'd0;
                        n_state   = S_COL;
                    end else begin
                        n_row_cnt = r_row_cnt + 2'd1;
                        n_state   = S_IDLE;
                    end
                end
            end
            S_COL: begin
                if (w_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_cnt   <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row_cnt   <= n_row_cnt;
            r_out_valid <= n_out_valid;
        end
        if (r_state == S_IDLE && i_valid) begin
            r_frac_x <= i_frac_x;
        end
        if (r_state == S_ROW && w_done && r_row_cnt != 2'd3) begin
            r_rows[r_row_cnt] <= w_wrapped;
        end
        if (r_state == S_OUT && w_out_free) begin
            r_out_data <= w_wrapped;
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_interpolated = r_out_data;

endmodule
